// ===== src/gle_pkg.sv =====
// ----------------------------------------------------------------------------
// gle_pkg
// Shared types, constants and GF(2^8) arithmetic for the Lagrange encoder.
// ----------------------------------------------------------------------------
package gle_pkg;

  localparam int unsigned SymW      = 8;
  localparam int unsigned LaneCnt   = 8;
  localparam int unsigned WordW     = SymW * LaneCnt;
  localparam int unsigned PolyW     = 9;
  localparam int unsigned CountW    = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned StepW     = 3;
  localparam int unsigned InvRounds = 7;

  localparam int unsigned DefMaxInputs  = 8;
  localparam int unsigned DefMaxOutputs = 8;

  localparam logic [PolyW-1:0]  PolyRst = 9'h11d;
  localparam logic [CountW-1:0] NinRst  = 4'd5;
  localparam logic [CountW-1:0] NoutRst = 4'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POLY = 3'd0,
    REG_NIN  = 3'd1,
    REG_NOUT = 3'd2,
    REG_XPTS = 3'd3,
    REG_YPTS = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_PROD,
    ST_SQR,
    ST_MUL,
    ST_FINAL,
    ST_IDLE
  } coef_st_e;

  typedef logic [SymW-1:0] sym_t;

  function automatic sym_t gf_mul(sym_t a, sym_t b, sym_t taps);
    sym_t acc;
    sym_t x;
    acc = '0;
    x   = a;
    for (int k = 0; k < SymW; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = x[SymW-1] ? ({x[SymW-2:0], 1'b0} ^ taps) : {x[SymW-2:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

// ===== src/gle_in_if.sv =====
// ----------------------------------------------------------------------------
// gle_in_if
// Stripe input channel: valid/ready with data symbols and last flag.
// ----------------------------------------------------------------------------
interface gle_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_symbols;
  logic        last_in;

  modport source (output valid, output data_symbols, output last_in, input ready);
  modport sink   (input valid, input data_symbols, input last_in, output ready);
endinterface

// ===== src/gle_out_if.sv =====
// ----------------------------------------------------------------------------
// gle_out_if
// Parity output channel: valid/ready with parity symbols and last flag.
// ----------------------------------------------------------------------------
interface gle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] parity_symbols;
  logic        last_out;

  modport source (output valid, output parity_symbols, output last_out, input ready);
  modport sink   (input valid, input parity_symbols, input last_out, output ready);
endinterface

// ===== src/gf256_lagrange_erasure_encoder_top.sv =====
// ----------------------------------------------------------------------------
// gf256_lagrange_erasure_encoder_top
// GF(2^8) Lagrange erasure encoder, one stripe per cycle while idle and out_o is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one stripe per transfer: one byte per input shard plus a
//         last flag. out_o returns one transfer per stripe: one parity byte
//         per output shard (unused lanes zero) and the copied last flag.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the field polynomial, shard counts
//   and evaluation points; write only while the block is idle.
//   After reset and after every configuration write, a coefficient
//   sequencer runs (init, 8 product steps, 14 inversion steps of the
//   per-lane GF multipliers, final scaling); in_i.ready stays low meanwhile.
//   A stripe passes the input register, then the result register, to out_o.
//   Throughput: one stripe per cycle while idle and out_o is not stalled.
//   When out_o is stalled, the input register still takes one more stripe,
//   then in_i.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module gf256_lagrange_erasure_encoder_top
  import gle_pkg::*;
#(
  parameter int unsigned MAX_INPUTS  = DefMaxInputs,
  parameter int unsigned MAX_OUTPUTS = DefMaxOutputs
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i,
  gle_in_if.sink             in_i,
  gle_out_if.source          out_o
);

  logic [PolyW-1:0]  poly_q;
  logic [CountW-1:0] nin_q, nout_q;
  logic [WordW-1:0]  xpts_q, ypts_q;
  logic [CountW-1:0] nin, nout;
  sym_t              taps;

  coef_st_e          st_q, st_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic              busy;

  sym_t num_q  [MAX_OUTPUTS][MAX_INPUTS];
  sym_t coef_q [MAX_OUTPUTS][MAX_INPUTS];
  sym_t den_q  [MAX_INPUTS];
  sym_t sq_q   [MAX_INPUTS];
  sym_t acc_q  [MAX_INPUTS];

  logic             s1_vld_q, s1_last_q, s1_adv;
  logic [WordW-1:0] s1_data_q;
  logic             out_vld_q, out_last_q;
  logic [WordW-1:0] out_par_q, par_d;

  assign taps = poly_q[SymW-1:0];
  assign nin  = (nin_q > CountW'(MAX_INPUTS)) ? CountW'(MAX_INPUTS) : nin_q;
  assign nout = (nout_q > CountW'(MAX_OUTPUTS)) ? CountW'(MAX_OUTPUTS) : nout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyRst;
      nin_q  <= NinRst;
      nout_q <= NoutRst;
      xpts_q <= '0;
      ypts_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLY: poly_q <= cfg_data_i[PolyW-1:0];
        REG_NIN:  nin_q  <= cfg_data_i[CountW-1:0];
        REG_NOUT: nout_q <= cfg_data_i[CountW-1:0];
        REG_XPTS: xpts_q <= cfg_data_i;
        REG_YPTS: ypts_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Coefficient sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_INIT;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    unique case (st_q)
      ST_INIT: begin
        st_d  = ST_PROD;
        cnt_d = '0;
      end
      ST_PROD: begin
        if (cnt_q == StepW'(MAX_INPUTS - 1)) begin
          st_d  = ST_SQR;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SQR: st_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == StepW'(InvRounds - 1)) begin
          st_d = ST_FINAL;
        end else begin
          st_d  = ST_SQR;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINAL: st_d = ST_IDLE;
      ST_IDLE:  st_d = ST_IDLE;
      default:  st_d = ST_INIT;
    endcase
    if (cfg_we_i) begin
      st_d = ST_INIT;
    end
  end

  assign busy = (st_q != ST_IDLE);

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_INIT: begin
        for (int i = 0; i < MAX_INPUTS; i++) begin
          den_q[i] <= 8'd1;
          for (int j = 0; j < MAX_OUTPUTS; j++) begin
            num_q[j][i] <= 8'd1;
          end
        end
      end
      ST_PROD: begin
        for (int i = 0; i < MAX_INPUTS; i++) begin
          if ({1'b0, cnt_q} < nin && int'(cnt_q) != i) begin
            den_q[i] <= gf_mul(den_q[i],
                               xpts_q[SymW*i +: SymW] ^ xpts_q[SymW*cnt_q +: SymW], taps);
            for (int j = 0; j < MAX_OUTPUTS; j++) begin
              num_q[j][i] <= gf_mul(num_q[j][i],
                                    ypts_q[SymW*j +: SymW] ^ xpts_q[SymW*cnt_q +: SymW],
                                    taps);
            end
          end
        end
        for (int i = 0; i < MAX_INPUTS; i++) begin
          acc_q[i] <= 8'd1;
        end
      end
      ST_SQR: begin
        for (int i = 0; i < MAX_INPUTS; i++) begin
          sq_q[i] <= (cnt_q == '0) ? gf_mul(den_q[i], den_q[i], taps) :
                                     gf_mul(sq_q[i], sq_q[i], taps);
        end
      end
      ST_MUL: begin
        for (int i = 0; i < MAX_INPUTS; i++) begin
          acc_q[i] <= gf_mul(acc_q[i], sq_q[i], taps);
        end
      end
      ST_FINAL: begin
        for (int j = 0; j < MAX_OUTPUTS; j++) begin
          for (int i = 0; i < MAX_INPUTS; i++) begin
            coef_q[j][i] <= (CountW'(i) < nin && CountW'(j) < nout) ?
                            gf_mul(num_q[j][i], acc_q[i], taps) : 8'd0;
          end
        end
      end
      default: ;
    endcase
  end

  // Stripe datapath
  assign s1_adv      = !out_vld_q || out_o.ready;
  assign in_i.ready  = !busy && (!s1_vld_q || s1_adv);

  always_comb begin
    par_d = '0;
    for (int j = 0; j < MAX_OUTPUTS; j++) begin
      for (int i = 0; i < MAX_INPUTS; i++) begin
        par_d[SymW*j +: SymW] = par_d[SymW*j +: SymW] ^
                                gf_mul(coef_q[j][i], s1_data_q[SymW*i +: SymW], taps);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_vld_q <= in_i.valid;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_data_q <= in_i.data_symbols;
      s1_last_q <= in_i.last_in;
    end
    if (s1_adv && s1_vld_q) begin
      out_par_q  <= par_d;
      out_last_q <= s1_last_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.parity_symbols = out_par_q;
  assign out_o.last_out       = out_last_q;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> st_q == ST_IDLE)
    else $error("ready while coefficients are recomputed");
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_i.ready)
    else $error("ready right after a configuration write");
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && out_vld_q && !out_o.ready |=> s1_vld_q)
    else $error("stalled stripe lost from input register");
`endif

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives stripes through the GF(2^8) Lagrange encoder over several field
// polynomials, shard counts and point sets, and checks every parity transfer
// against an independent prediction of the Lagrange combination.
// ----------------------------------------------------------------------------
module testbench;
  import gle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] parity;
    logic        last;
  } parity_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [WordW-1:0]  cfg_data_i;

  gle_in_if  in_if ();
  gle_out_if out_if ();

  gf256_lagrange_erasure_encoder_top i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if.sink),
    .out_o     (out_if.source)
  );

  logic [8:0]  poly_q;
  logic [3:0]  nin_q;
  logic [3:0]  nout_q;
  logic [63:0] xpts_q;
  logic [63:0] ypts_q;

  parity_t     parity_queue[$];
  int unsigned err_cnt;
  int unsigned stripe_cnt;
  int unsigned parity_cnt;
  int unsigned cfg_cnt;
  bit          no_idle;
  int unsigned hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] mul_gf8(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    logic [8:0] x;
    acc = '0;
    x = {1'b0, a};
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x[7:0];
      x = x << 1;
      if (x[8]) x = {1'b0, x[7:0] ^ poly_q[7:0]};
    end
    return acc;
  endfunction

  function automatic logic [7:0] inv_gf8(logic [7:0] a);
    logic [7:0] r;
    r = 8'd1;
    for (int k = 0; k < 254; k++) r = mul_gf8(r, a);
    return r;
  endfunction

  function automatic logic [63:0] lagrange_parity(logic [63:0] data);
    logic [63:0] res;
    logic [7:0]  sum, coef, xi, xp, y;
    int          n, m;
    res = '0;
    n = (nin_q > 8) ? 8 : nin_q;
    m = (nout_q > 8) ? 8 : nout_q;
    for (int j = 0; j < m; j++) begin
      y = ypts_q[8*j +: 8];
      sum = '0;
      for (int i = 0; i < n; i++) begin
        xi = xpts_q[8*i +: 8];
        coef = 8'd1;
        for (int p = 0; p < n; p++) begin
          if (p != i) begin
            xp = xpts_q[8*p +: 8];
            coef = mul_gf8(coef, mul_gf8(y ^ xp, inv_gf8(xi ^ xp)));
          end
        end
        sum ^= mul_gf8(coef, data[8*i +: 8]);
      end
      res[8*j +: 8] = sum;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h (transfer %0d)", what, got, want, parity_cnt);
    err_cnt++;
  endtask

  // output side: random stall, plus a long hold when requested
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin
    parity_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (parity_queue.size() == 0) begin
          report_mismatch("unexpected", out_if.parity_symbols, '0);
        end else begin
          want = parity_queue.pop_front();
          if (out_if.parity_symbols !== want.parity)
            report_mismatch("parity", out_if.parity_symbols, want.parity);
          if (out_if.last_out !== want.last)
            report_mismatch("last", 64'(out_if.last_out), 64'(want.last));
        end
        parity_cnt++;
      end
    end
  end

  task automatic send_stripe(logic [63:0] data, logic last);
    parity_t e;
    while (!no_idle && $urandom_range(99) < 23) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.data_symbols <= data;
    in_if.last_in      <= last;
    e.parity = lagrange_parity(data);
    e.last   = last;
    parity_queue.push_back(e);
    do @(posedge clk_i); while (!in_if.ready);
    stripe_cnt++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (parity_queue.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    case (idx)
      REG_POLY: poly_q = val[8:0];
      REG_NIN:  nin_q  = val[3:0];
      REG_NOUT: nout_q = val[3:0];
      REG_XPTS: xpts_q = val;
      REG_YPTS: ypts_q = val;
      default: ;
    endcase
    cfg_cnt++;
  endtask

  task automatic set_code(logic [8:0] poly, logic [3:0] nin, logic [3:0] nout,
                          logic [63:0] xp, logic [63:0] yp);
    drain();
    write_reg(REG_POLY, 64'(poly));
    write_reg(REG_NIN, 64'(nin));
    write_reg(REG_NOUT, 64'(nout));
    write_reg(REG_XPTS, xp);
    write_reg(REG_YPTS, yp);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_config();
    send_stripe(64'h0807060504030201, 1'b0);
    send_stripe('1, 1'b1);
  endtask

  task automatic test_directed();
    set_code(9'h11d, 4'd8, 4'd8, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    send_stripe('0, 1'b0);
    send_stripe('1, 1'b1);
    send_stripe(64'h0102040810204080, 1'b0);
    set_code(9'h0a9, 4'd15, 4'd15, 64'h8040201008040201, 64'hfedcba9876543210);
    send_stripe(64'h5555aaaa5555aaaa, 1'b1);
    send_stripe(rand_word(), 1'b0);
    set_code(9'h1ff, 4'd0, 4'd8, 64'h1122334455667788, 64'h99aabbccddeeff00);
    send_stripe('1, 1'b0);
    set_code(9'h100, 4'd8, 4'd0, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
    send_stripe('1, 1'b1);
    set_code(9'h11d, 4'd4, 4'd4, 64'h0000000003030100, 64'hffffffff00000000);
    send_stripe(64'hdeadbeefcafef00d, 1'b0);
    set_code(9'h12b, 4'd1, 4'd1, 64'hff, 64'hff);
    send_stripe(64'h00000000000000ff, 1'b1);
    // bad register index must be ignored
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= 3'd7;
    cfg_data_i <= '1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    send_stripe(64'h0000000000000077, 1'b0);
  endtask

  task automatic test_backpressure();
    set_code(9'h11d, 4'd6, 4'd4, rand_word(), rand_word());
    hold_cycles = 60;
    for (int k = 0; k < 20; k++) send_stripe(rand_word(), k[0]);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 16; phase++) begin
      set_code(9'(9'h100 | $urandom_range(255)) ^ 9'($urandom_range(1) << 8),
               4'($urandom_range(15)), 4'($urandom_range(15)), rand_word(), rand_word());
      no_idle = (phase == 5);
      for (int k = 0; k < 100; k++) send_stripe(rand_word(), 1'($urandom_range(1)));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data_symbols = '0;
    in_if.last_in = 1'b0;
    poly_q = PolyRst;
    nin_q = NinRst;
    nout_q = NoutRst;
    xpts_q = '0;
    ypts_q = '0;
    err_cnt = 0;
    stripe_cnt = 0;
    parity_cnt = 0;
    cfg_cnt = 0;
    no_idle = 1'b0;
    hold_cycles = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_config();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    $display("Covered %0d stripes, %0d parity transfers, %0d register writes.",
             stripe_cnt, parity_cnt, cfg_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/gle_pkg.sv
src/gle_in_if.sv
src/gle_out_if.sv
src/gf256_lagrange_erasure_encoder_top.sv
test/testbench.sv
